### hdl/cff_pkg.sv
// ----------------------------------------------------------------------------
// CPUID feature filter package
// Shared types, leaf codes, request classes and feature masks.
// ----------------------------------------------------------------------------
package cff_pkg;

  // Register file layout
  localparam int unsigned CFG_ADDR_W = 6;
  localparam logic [2:0] REG_XSTATE_MASK = 3'd0;
  localparam logic [2:0] REG_VCPU_NUMBER = 3'd1;
  localparam logic [2:0] REG_SIG_EBX     = 3'd2;
  localparam logic [2:0] REG_SIG_ECX     = 3'd3;
  localparam logic [2:0] REG_SIG_EDX     = 3'd4;

  // Leaf codes
  localparam logic [31:0] LEAF_MAX_BASIC = 32'h0000_0000;
  localparam logic [31:0] LEAF_FEATURES  = 32'h0000_0001;
  localparam logic [31:0] LEAF_THERMAL   = 32'h0000_0006;
  localparam logic [31:0] LEAF_EXT_FEAT  = 32'h0000_0007;
  localparam logic [31:0] LEAF_TOPOLOGY  = 32'h0000_000B;
  localparam logic [31:0] LEAF_XSTATE    = 32'h0000_000D;
  localparam logic [31:0] LEAF_HV_BASE   = 32'h4000_0000;
  localparam logic [31:0] LEAF_HV_LAST   = 32'h4000_00FF;
  localparam logic [31:0] LEAF_EXT_INFO  = 32'h8000_0001;
  localparam logic [31:0] LEAF_SVM       = 32'h8000_000A;
  localparam logic [31:0] MAX_BASIC      = 32'h0000_000D;

  // Request classes decided by the front end
  typedef logic [3:0] cls_t;
  localparam cls_t CLS_PASS    = 4'd0;
  localparam cls_t CLS_ZERO    = 4'd1;
  localparam cls_t CLS_HV_BASE = 4'd2;
  localparam cls_t CLS_XS_MAIN = 4'd3;
  localparam cls_t CLS_XS_SUB1 = 4'd4;
  localparam cls_t CLS_FEAT    = 4'd5;
  localparam cls_t CLS_EXTF    = 4'd6;
  localparam cls_t CLS_EXTINFO = 4'd7;
  localparam cls_t CLS_MAXLEAF = 4'd8;

  // Leaf 1 ecx and ebx bits
  localparam logic [31:0] L1_C_HIDE = (32'd1 << 3) | (32'd1 << 5) | (32'd1 << 6) |
                                      (32'd1 << 27);
  localparam int unsigned L1_C_XSAVE   = 26;
  localparam int unsigned L1_C_OSXSAVE = 27;
  localparam int unsigned L1_C_AVX     = 28;
  localparam int unsigned L1_C_HV      = 31;
  localparam logic [31:0] L1_B_KEEP    = 32'h00FF_FFFF;

  // Leaf 7 sub-leaf 0 bits
  localparam int unsigned L7_B_AVX2 = 5;
  localparam logic [31:0] L7_B_AVX512 = (32'd1 << 16) | (32'd1 << 17) | (32'd1 << 21) |
                                        (32'd1 << 26) | (32'd1 << 27) | (32'd1 << 28) |
                                        (32'd1 << 30) | (32'd1 << 31);
  localparam logic [31:0] L7_C_AVX512 = (32'd1 << 1) | (32'd1 << 6) | (32'd1 << 11) |
                                        (32'd1 << 12) | (32'd1 << 14);
  localparam logic [31:0] L7_D_AVX512 = (32'd1 << 2) | (32'd1 << 3) | (32'd1 << 8) |
                                        (32'd1 << 23);

  // Extended state components
  localparam int unsigned XS_AVX    = 2;
  localparam int unsigned XS_AVX512 = 5;

  // Leaf 0x80000001 ecx SVM bit
  localparam int unsigned EXT_C_SVM = 2;

  // Queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One classified request
  typedef struct packed {
    cls_t        cls;
    logic        osx;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] hc;
    logic [31:0] hd;
  } req_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [63:0] xstate_mask;
    logic [7:0]  vcpu_number;
    logic [31:0] sig_ebx;
    logic [31:0] sig_ecx;
    logic [31:0] sig_edx;
  } cfg_t;

endpackage

### hdl/cff_front.sv
// ----------------------------------------------------------------------------
// CPUID feature filter front end
// Accepts requests and sorts each one into a class for the back end.
// ----------------------------------------------------------------------------
module cff_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     in_leaf,
  input  logic [31:0]     in_subleaf,
  input  logic [31:0]     in_host_a,
  input  logic [31:0]     in_host_b,
  input  logic [31:0]     in_host_c,
  input  logic [31:0]     in_host_d,
  input  logic            in_guest_osxsave,
  input  logic            q_full,
  output logic            q_push,
  output cff_pkg::req_t   q_data
);
  import cff_pkg::*;

  cls_t cls;
  logic in_hv_range;

  // Requests enter as long as the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign in_hv_range = (in_leaf >= LEAF_HV_BASE) && (in_leaf <= LEAF_HV_LAST);

  // Leaf classification, in priority order.
  always_comb begin
    if (in_hv_range) begin
      cls = (in_leaf == LEAF_HV_BASE) ? CLS_HV_BASE : CLS_ZERO;
    end else if (in_leaf == LEAF_THERMAL || in_leaf == LEAF_TOPOLOGY ||
                 in_leaf == LEAF_SVM ||
                 (in_leaf == LEAF_XSTATE && in_subleaf > 32'd1)) begin
      cls = CLS_ZERO;
    end else if (in_leaf == LEAF_XSTATE) begin
      cls = (in_subleaf == 32'd0) ? CLS_XS_MAIN : CLS_XS_SUB1;
    end else if (in_leaf == LEAF_FEATURES) begin
      cls = CLS_FEAT;
    end else if (in_leaf == LEAF_EXT_FEAT && in_subleaf == 32'd0) begin
      cls = CLS_EXTF;
    end else if (in_leaf == LEAF_EXT_INFO) begin
      cls = CLS_EXTINFO;
    end else if (in_leaf == LEAF_MAX_BASIC) begin
      cls = CLS_MAXLEAF;
    end else begin
      cls = CLS_PASS;
    end
  end

  assign q_data = '{cls: cls, osx: in_guest_osxsave, ha: in_host_a, hb: in_host_b,
                    hc: in_host_c, hd: in_host_d};

endmodule

### hdl/cff_queue.sv
// ----------------------------------------------------------------------------
// CPUID feature filter request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cff_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cff_pkg::req_t push_data,
  input  logic          pop,
  output cff_pkg::req_t head_data,
  output logic          not_empty,
  output logic          full
);
  import cff_pkg::*;

  req_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  // A request is never written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");

  // The fill count advances on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

### hdl/cff_back.sv
// ----------------------------------------------------------------------------
// CPUID feature filter back end
// Builds the guest-visible result words and holds them in an output register.
// ----------------------------------------------------------------------------
module cff_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cff_pkg::cfg_t cfg,
  input  logic          q_not_empty,
  input  cff_pkg::req_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_a,
  output logic [31:0]   out_b,
  output logic [31:0]   out_c,
  output logic [31:0]   out_d
);
  import cff_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic        xs_any;
  logic        load;

  assign xs_any = (cfg.xstate_mask != 64'd0);

  // The output register loads from a non-empty queue whenever it is empty or being drained.
  assign load      = q_not_empty && (!valid_r || out_ready);
  assign q_pop     = load;
  assign valid_nxt = load || (valid_r && !out_ready);

  // Result words for the request at the head of the queue.
  always_comb begin
    a_nxt = q_head.ha;
    b_nxt = q_head.hb;
    c_nxt = q_head.hc;
    d_nxt = q_head.hd;
    case (q_head.cls)
      CLS_ZERO: begin
        a_nxt = '0;
        b_nxt = '0;
        c_nxt = '0;
        d_nxt = '0;
      end
      CLS_HV_BASE: begin
        a_nxt = LEAF_HV_BASE;
        b_nxt = cfg.sig_ebx;
        c_nxt = cfg.sig_ecx;
        d_nxt = cfg.sig_edx;
      end
      CLS_XS_MAIN: begin
        a_nxt = cfg.xstate_mask[31:0];
        d_nxt = cfg.xstate_mask[63:32];
        c_nxt = xs_any ? q_head.hb : '0;
        b_nxt = xs_any ? q_head.hb : '0;
      end
      CLS_XS_SUB1: begin
        a_nxt = {31'd0, q_head.ha[0] & xs_any};
        b_nxt = '0;
        c_nxt = '0;
        d_nxt = '0;
      end
      CLS_FEAT: begin
        b_nxt = (q_head.hb & L1_B_KEEP) | {cfg.vcpu_number, 24'd0};
        c_nxt = q_head.hc & ~L1_C_HIDE;
        c_nxt[L1_C_HV] = 1'b1;
        if (!xs_any) begin
          c_nxt[L1_C_XSAVE] = 1'b0;
        end else if (q_head.osx) begin
          c_nxt[L1_C_OSXSAVE] = 1'b1;
        end
        if (!cfg.xstate_mask[XS_AVX]) begin
          c_nxt[L1_C_AVX] = 1'b0;
        end
      end
      CLS_EXTF: begin
        if (!cfg.xstate_mask[XS_AVX]) begin
          b_nxt[L7_B_AVX2] = 1'b0;
        end
        if (!cfg.xstate_mask[XS_AVX512]) begin
          b_nxt = b_nxt & ~L7_B_AVX512;
          c_nxt = q_head.hc & ~L7_C_AVX512;
          d_nxt = q_head.hd & ~L7_D_AVX512;
        end
      end
      CLS_EXTINFO: begin
        c_nxt[EXT_C_SVM] = 1'b0;
      end
      CLS_MAXLEAF: begin
        a_nxt = (q_head.ha > MAX_BASIC) ? MAX_BASIC : q_head.ha;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_c     = c_r;
  assign out_d     = d_r;

endmodule

### hdl/cpuid_feature_filter.sv
// An accepted request goes into a queue entry, then into the output register as a result.
// Throughput: one request per cycle when unstalled; a two-entry queue feeds one output register.
// A stalled output fills the queue, and input ready drops once it holds two requests.
// Reset (synchronous, rst_n low) empties the queue and output and clears the config registers.
// ----------------------------------------------------------------------------
// CPUID feature filter
// Turns a host CPUID answer into the answer a guest may see.
// ----------------------------------------------------------------------------
module cpuid_feature_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cff_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  // Request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_leaf,
  input  logic [31:0]                    in_subleaf,
  input  logic [31:0]                    in_host_a,
  input  logic [31:0]                    in_host_b,
  input  logic [31:0]                    in_host_c,
  input  logic [31:0]                    in_host_d,
  input  logic                           in_guest_osxsave,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_a,
  output logic [31:0]                    out_b,
  output logic [31:0]                    out_c,
  output logic [31:0]                    out_d
);
  import cff_pkg::*;

  logic [63:0] xstate_mask_r;
  logic [7:0]  vcpu_number_r;
  logic [31:0] sig_ebx_r, sig_ecx_r, sig_edx_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  cfg_t        cfg;
  req_t        q_in, q_head;
  logic        q_push, q_pop, q_full, q_not_empty;

  // Register access decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xstate_mask_r <= '0;
      vcpu_number_r <= '0;
      sig_ebx_r     <= '0;
      sig_ecx_r     <= '0;
      sig_edx_r     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_XSTATE_MASK: xstate_mask_r <= pwdata;
        REG_VCPU_NUMBER: vcpu_number_r <= pwdata[7:0];
        REG_SIG_EBX:     sig_ebx_r     <= pwdata[31:0];
        REG_SIG_ECX:     sig_ecx_r     <= pwdata[31:0];
        REG_SIG_EDX:     sig_edx_r     <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_XSTATE_MASK: prdata = xstate_mask_r;
      REG_VCPU_NUMBER: prdata = {56'd0, vcpu_number_r};
      REG_SIG_EBX:     prdata = {32'd0, sig_ebx_r};
      REG_SIG_ECX:     prdata = {32'd0, sig_ecx_r};
      REG_SIG_EDX:     prdata = {32'd0, sig_edx_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{xstate_mask: xstate_mask_r, vcpu_number: vcpu_number_r,
                 sig_ebx: sig_ebx_r, sig_ecx: sig_ecx_r, sig_edx: sig_edx_r};

  // Front end: accept and classify.
  cff_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_leaf          (in_leaf),
    .in_subleaf       (in_subleaf),
    .in_host_a        (in_host_a),
    .in_host_b        (in_host_b),
    .in_host_c        (in_host_c),
    .in_host_d        (in_host_d),
    .in_guest_osxsave (in_guest_osxsave),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  // Request queue between the two halves.
  cff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back end: build and present results.
  cff_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_c       (out_c),
    .out_d       (out_d)
  );

endmodule

### dv/cpuid_feature_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CPUID feature filter testbench
// Drives CPUID requests through the filter under random source gaps and sink
// stalls, and compares every guest answer with a local copy of the masking
// rules. Register writes change the filter setup between traffic phases and
// are read back over the configuration port.
// ----------------------------------------------------------------------------
module cpuid_feature_filter_tb;
  import cff_pkg::*;

  localparam logic [31:0] ONES        = 32'hFFFF_FFFF;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 100;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] leaf;
    logic [31:0] subleaf;
    logic [31:0] host_a;
    logic [31:0] host_b;
    logic [31:0] host_c;
    logic [31:0] host_d;
    logic        osxsave;
  } cpuid_req_t;

  typedef struct packed {
    logic [31:0] eax;
    logic [31:0] ebx;
    logic [31:0] ecx;
    logic [31:0] edx;
  } guest_regs_t;

  typedef enum logic {STEP_REQUEST, STEP_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    logic [2:0]  reg_idx;
    logic [63:0] reg_val;
    cpuid_req_t  req;
    logic        known;
    guest_regs_t want;
  } plan_step_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_leaf;
  logic [31:0] in_subleaf;
  logic [31:0] in_host_a;
  logic [31:0] in_host_b;
  logic [31:0] in_host_c;
  logic [31:0] in_host_d;
  logic        in_guest_osxsave;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic [31:0] out_d;

  // Local copy of the filter registers.
  logic [63:0] kept_xstate;
  logic [7:0]  apic_id;
  logic [31:0] sig_ebx;
  logic [31:0] sig_ecx;
  logic [31:0] sig_edx;

  guest_regs_t guest_view_q[$];
  plan_step_t  plan_q[$];

  int  mismatches;
  int  requests_sent;
  int  answers_checked;
  int  reg_writes;
  int  cycles;
  int  sink_hold;
  int  sink_roll;
  bit  src_steady;
  bit  sink_steady;

  cpuid_feature_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_leaf          (in_leaf),
    .in_subleaf       (in_subleaf),
    .in_host_a        (in_host_a),
    .in_host_b        (in_host_b),
    .in_host_c        (in_host_c),
    .in_host_d        (in_host_d),
    .in_guest_osxsave (in_guest_osxsave),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_a            (out_a),
    .out_b            (out_b),
    .out_c            (out_c),
    .out_d            (out_d)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d answers pending",
               CYCLE_LIMIT, guest_view_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Guest-visible answer for one request under the current register setup.
  function automatic guest_regs_t guest_view(cpuid_req_t r);
    guest_regs_t g;
    g = '0;
    if (r.leaf >= LEAF_HV_BASE && r.leaf <= LEAF_HV_LAST) begin
      // Hypervisor range: signature at the base leaf, zeros elsewhere.
      if (r.leaf == LEAF_HV_BASE) begin
        g.eax = LEAF_HV_BASE;
        g.ebx = sig_ebx;
        g.ecx = sig_ecx;
        g.edx = sig_edx;
      end
    end else if (r.leaf == LEAF_THERMAL || r.leaf == LEAF_TOPOLOGY || r.leaf == LEAF_SVM ||
                 (r.leaf == LEAF_XSTATE && r.subleaf > 32'd1)) begin
      // Hidden leaves answer with zeros.
    end else if (r.leaf == LEAF_XSTATE) begin
      if (kept_xstate != 64'd0) begin
        if (r.subleaf == 32'd0) begin
          g.eax = kept_xstate[31:0];
          g.edx = kept_xstate[63:32];
          g.ebx = r.host_b;
          g.ecx = r.host_b;
        end else begin
          g.eax = {31'd0, r.host_a[0]};
        end
      end
    end else begin
      g.eax = r.host_a;
      g.ebx = r.host_b;
      g.ecx = r.host_c;
      g.edx = r.host_d;
      if (r.leaf == LEAF_FEATURES) begin
        // Hide MONITOR, VMX, SMX and OSXSAVE, advertise the hypervisor.
        g.ecx = g.ecx & ~L1_C_HIDE;
        g.ecx[L1_C_HV] = 1'b1;
        g.ebx = (g.ebx & L1_B_KEEP) | {apic_id, 24'd0};
        if (kept_xstate == 64'd0) begin
          g.ecx[L1_C_XSAVE] = 1'b0;
        end else if (r.osxsave) begin
          g.ecx[L1_C_OSXSAVE] = 1'b1;
        end
        if (!kept_xstate[XS_AVX]) begin
          g.ecx[L1_C_AVX] = 1'b0;
        end
      end else if (r.leaf == LEAF_EXT_FEAT && r.subleaf == 32'd0) begin
        if (!kept_xstate[XS_AVX]) begin
          g.ebx[L7_B_AVX2] = 1'b0;
        end
        if (!kept_xstate[XS_AVX512]) begin
          g.ebx = g.ebx & ~L7_B_AVX512;
          g.ecx = g.ecx & ~L7_C_AVX512;
          g.edx = g.edx & ~L7_D_AVX512;
        end
      end else if (r.leaf == LEAF_EXT_INFO) begin
        g.ecx[EXT_C_SVM] = 1'b0;
      end else if (r.leaf == LEAF_MAX_BASIC) begin
        if (g.eax > MAX_BASIC) begin
          g.eax = MAX_BASIC;
        end
      end
    end
    return g;
  endfunction

  // Source gap: mostly none, some short, a few long.
  function automatic int source_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (src_steady || roll < 60) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] random_word();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? ONES : 32'd0;
    end
    return $urandom;
  endfunction

  // Random request biased toward the leaves the filter treats specially.
  function automatic cpuid_req_t random_request();
    cpuid_req_t r;
    case ($urandom_range(0, 15))
      0:       r.leaf = LEAF_MAX_BASIC;
      1, 2:    r.leaf = LEAF_FEATURES;
      3:       r.leaf = LEAF_THERMAL;
      4, 5:    r.leaf = LEAF_EXT_FEAT;
      6:       r.leaf = LEAF_TOPOLOGY;
      7, 8:    r.leaf = LEAF_XSTATE;
      9:       r.leaf = LEAF_HV_BASE;
      10:      r.leaf = LEAF_HV_BASE + $urandom_range(1, 255);
      11:      r.leaf = LEAF_EXT_INFO;
      12:      r.leaf = LEAF_SVM;
      13: begin
        case ($urandom_range(0, 3))
          0:       r.leaf = LEAF_HV_BASE - 32'd1;
          1:       r.leaf = LEAF_HV_LAST + 32'd1;
          2:       r.leaf = ONES;
          default: r.leaf = LEAF_SVM - 32'd1;
        endcase
      end
      default: r.leaf = $urandom;
    endcase
    r.subleaf = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2));
    r.host_a  = random_word();
    r.host_b  = random_word();
    r.host_c  = random_word();
    r.host_d  = random_word();
    r.osxsave = 1'($urandom_range(0, 1));
    // Keep the maximum basic leaf near the clamp point half of the time.
    if (r.leaf == LEAF_MAX_BASIC && $urandom_range(0, 1) == 1) begin
      r.host_a = $urandom_range(0, 20);
    end
    return r;
  endfunction

  function automatic void plan_req(logic [31:0] leaf, logic [31:0] subleaf,
                                   logic [31:0] ha, logic [31:0] hb, logic [31:0] hc,
                                   logic [31:0] hd, logic osx);
    plan_step_t s;
    s = '0;
    s.kind        = STEP_REQUEST;
    s.req.leaf    = leaf;
    s.req.subleaf = subleaf;
    s.req.host_a  = ha;
    s.req.host_b  = hb;
    s.req.host_c  = hc;
    s.req.host_d  = hd;
    s.req.osxsave = osx;
    plan_q.push_back(s);
  endfunction

  // Request whose answer is obvious; host words all equal, OSXSAVE set.
  function automatic void plan_known(logic [31:0] leaf, logic [31:0] subleaf,
                                     logic [31:0] host, logic [31:0] wa, logic [31:0] wb,
                                     logic [31:0] wc, logic [31:0] wd);
    plan_step_t s;
    s = '0;
    s.kind        = STEP_REQUEST;
    s.req.leaf    = leaf;
    s.req.subleaf = subleaf;
    s.req.host_a  = host;
    s.req.host_b  = host;
    s.req.host_c  = host;
    s.req.host_d  = host;
    s.req.osxsave = 1'b1;
    s.known       = 1'b1;
    s.want.eax    = wa;
    s.want.ebx    = wb;
    s.want.ecx    = wc;
    s.want.edx    = wd;
    plan_q.push_back(s);
  endfunction

  function automatic void plan_write(logic [2:0] idx, logic [63:0] val);
    plan_step_t s;
    s = '0;
    s.kind    = STEP_WRITE;
    s.reg_idx = idx;
    s.reg_val = val;
    plan_q.push_back(s);
  endfunction

  // Offer one request and hold it until accepted; record what the guest should see.
  task automatic send_request(cpuid_req_t r, logic known, guest_regs_t want);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_leaf          <= r.leaf;
    in_subleaf       <= r.subleaf;
    in_host_a        <= r.host_a;
    in_host_b        <= r.host_b;
    in_host_c        <= r.host_c;
    in_host_d        <= r.host_d;
    in_guest_osxsave <= r.osxsave;
    do @(posedge clk); while (in_ready !== 1'b1);
    guest_view_q.push_back(known ? want : guest_view(r));
    requests_sent++;
  endtask

  // Stop the source and wait until every answer is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (guest_view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register while idle, then read it back if it exists.
  task automatic write_register(logic [2:0] idx, logic [63:0] val);
    logic [63:0] keep_bits;
    logic [63:0] held;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    keep_bits = 64'd0;
    held      = 64'd0;
    case (idx)
      REG_XSTATE_MASK: begin
        kept_xstate = val;
        keep_bits   = ~64'd0;
        held        = kept_xstate;
      end
      REG_VCPU_NUMBER: begin
        apic_id   = val[7:0];
        keep_bits = 64'hFF;
        held      = {56'd0, apic_id};
      end
      REG_SIG_EBX: begin
        sig_ebx   = val[31:0];
        keep_bits = 64'hFFFF_FFFF;
        held      = {32'd0, sig_ebx};
      end
      REG_SIG_ECX: begin
        sig_ecx   = val[31:0];
        keep_bits = 64'hFFFF_FFFF;
        held      = {32'd0, sig_ecx};
      end
      REG_SIG_EDX: begin
        sig_edx   = val[31:0];
        keep_bits = 64'hFFFF_FFFF;
        held      = {32'd0, sig_edx};
      end
      default: begin
      end
    endcase
    if (keep_bits != 64'd0) begin
      // The read setup cycle follows the write directly with psel held high.
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      if ((prdata & keep_bits) !== held) begin
        $error("register %0d readback: expected %h, got %h", idx, held, prdata & keep_bits);
        mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end else begin
      psel    <= 1'b0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Sink readiness: random stalls, short mostly, with occasional long ones.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        sink_hold <= (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // Compare each answer the guest receives with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (guest_view_q.size() == 0) begin
        $error("answer %h %h %h %h with no request pending", out_a, out_b, out_c, out_d);
        mismatches++;
      end else begin
        check_field("out_a", guest_view_q[0].eax, out_a);
        check_field("out_b", guest_view_q[0].ebx, out_b);
        check_field("out_c", guest_view_q[0].ecx, out_c);
        check_field("out_d", guest_view_q[0].edx, out_d);
        void'(guest_view_q.pop_front());
        answers_checked++;
      end
    end
  end

  initial begin
    cpuid_req_t  r;
    logic [63:0] mask;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid         = 1'b0;
    in_leaf          = '0;
    in_subleaf       = '0;
    in_host_a        = '0;
    in_host_b        = '0;
    in_host_c        = '0;
    in_host_d        = '0;
    in_guest_osxsave = 1'b0;
    kept_xstate      = '0;
    apic_id          = '0;
    sig_ebx          = '0;
    sig_ecx          = '0;
    sig_edx          = '0;
    mismatches       = 0;
    requests_sent    = 0;
    answers_checked  = 0;
    reg_writes       = 0;
    cycles           = 0;
    sink_hold        = 0;
    src_steady       = 1'b0;
    sink_steady      = 1'b0;

    // Directed part. With every register still at reset the hidden leaves,
    // the signature and the clamp are plain to read.
    plan_known(LEAF_HV_BASE, 32'd0, ONES, LEAF_HV_BASE, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_HV_BASE + 32'd1, ONES, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_HV_LAST, 32'd0, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_THERMAL, 32'd0, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_TOPOLOGY, 32'd1, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_SVM, 32'd0, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_XSTATE, 32'd0, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_XSTATE, 32'd1, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_XSTATE, 32'd2, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_XSTATE, ONES, ONES, 32'd0, 32'd0, 32'd0, 32'd0);
    plan_known(LEAF_MAX_BASIC, 32'd0, ONES, MAX_BASIC, ONES, ONES, ONES);
    plan_known(ONES, ONES, ONES, ONES, ONES, ONES, ONES);
    plan_req(LEAF_MAX_BASIC, 32'd0, 32'd12, 32'd0, 32'd0, 32'd0, 1'b0);
    plan_req(LEAF_FEATURES, 32'd0, ONES, ONES, ONES, ONES, 1'b1);
    plan_req(LEAF_EXT_FEAT, 32'd0, ONES, ONES, ONES, ONES, 1'b0);
    plan_req(LEAF_EXT_INFO, 32'd0, ONES, ONES, ONES, ONES, 1'b0);
    // Every register at its maximum, then writes past the list that must not stick.
    plan_write(REG_XSTATE_MASK, ~64'd0);
    plan_write(REG_VCPU_NUMBER, 64'hFF);
    plan_write(REG_SIG_EBX, {32'd0, ONES});
    plan_write(REG_SIG_ECX, {32'd0, ONES});
    plan_write(REG_SIG_EDX, {32'd0, ONES});
    plan_write(REG_UNUSED_LO, 64'd0);
    plan_write(REG_UNUSED_HI, 64'd0);
    plan_known(LEAF_HV_BASE, 32'd0, 32'd0, LEAF_HV_BASE, ONES, ONES, ONES);
    plan_req(LEAF_XSTATE, 32'd0, 32'h1234_5678, 32'h8765_4321, 32'd0, 32'd0, 1'b0);
    plan_req(LEAF_XSTATE, 32'd1, ONES, ONES, ONES, ONES, 1'b0);
    plan_req(LEAF_FEATURES, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    plan_req(LEAF_FEATURES, 32'd0, ONES, ONES, ONES, ONES, 1'b1);
    plan_req(LEAF_EXT_FEAT, 32'd0, ONES, ONES, ONES, ONES, 1'b0);
    plan_req(LEAF_EXT_FEAT, 32'd1, ONES, ONES, ONES, ONES, 1'b0);
    plan_req(LEAF_HV_BASE - 32'd1, 32'd0, ONES, ONES, ONES, ONES, 1'b0);
    plan_req(LEAF_HV_LAST + 32'd1, 32'd0, ONES, ONES, ONES, ONES, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == STEP_WRITE) begin
        write_register(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        send_request(plan_q[i].req, plan_q[i].known, plan_q[i].want);
      end
    end

    // Random phases, each under its own register setup; the first two at the extremes.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        mask = 64'd0;
      end else if (p == 1) begin
        mask = ~64'd0;
      end else begin
        case ($urandom_range(0, 5))
          0:       mask = 64'd0;
          1:       mask = ~64'd0;
          2:       mask = 64'd1 << XS_AVX;
          3:       mask = 64'd1 << XS_AVX512;
          4:       mask = (64'd1 << XS_AVX) | (64'd1 << XS_AVX512);
          default: mask = {32'($urandom), 32'($urandom)};
        endcase
      end
      write_register(REG_XSTATE_MASK, mask);
      write_register(REG_VCPU_NUMBER, (p == 0) ? 64'd0 : (p == 1) ? 64'hFF :
                                      64'($urandom_range(0, 255)));
      write_register(REG_SIG_EBX, (p == 0) ? 64'd0 : (p == 1) ? {32'd0, ONES} :
                                  {32'd0, 32'($urandom)});
      write_register(REG_SIG_ECX, (p == 0) ? 64'd0 : (p == 1) ? {32'd0, ONES} :
                                  {32'd0, 32'($urandom)});
      write_register(REG_SIG_EDX, (p == 0) ? 64'd0 : (p == 1) ? {32'd0, ONES} :
                                  {32'd0, 32'($urandom)});
      if ($urandom_range(0, 2) == 0) begin
        write_register(REG_UNUSED_LO, {32'($urandom), 32'($urandom)});
      end
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = random_request();
        send_request(r, 1'b0, '0);
      end
    end

    settle();
    $display("Sent %0d CPUID requests and checked %0d guest answers", requests_sent,
             answers_checked);
    $display("Covered %0d register writes over %0d random setups plus the directed ones",
             reg_writes, PHASES);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### cpuid_feature_filter.f
hdl/cff_pkg.sv
hdl/cff_front.sv
hdl/cff_queue.sv
hdl/cff_back.sv
hdl/cpuid_feature_filter.sv
dv/cpuid_feature_filter_tb.sv
